@@ rtl/core/msp_pkg.sv @@
// msp_pkg: types, codes and the status decode table of the MIDI stream parser.
// No dependencies; imported by midi_stream_parser_unit, the checker and the test.
`timescale 1ns / 1ps

package msp_pkg;

	localparam int MAX_RES    = 2;
	localparam int FIFO_DEPTH = 8;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	// input item kinds
	localparam logic [1:0] IK_BYTE    = 2'd0;
	localparam logic [1:0] IK_ABANDON = 2'd1;
	localparam logic [1:0] IK_RESET   = 2'd2;

	// result kinds
	localparam logic [2:0] RK_EVENT    = 3'd0;
	localparam logic [2:0] RK_SX_START = 3'd1;
	localparam logic [2:0] RK_SX_DATA  = 3'd2;
	localparam logic [2:0] RK_SX_END   = 3'd3;
	localparam logic [2:0] RK_SX_ABORT = 3'd4;

	// event type codes
	localparam logic [4:0] TY_NONE       = 5'd0;
	localparam logic [4:0] TY_NOTE_ON    = 5'd1;
	localparam logic [4:0] TY_NOTE_OFF   = 5'd2;
	localparam logic [4:0] TY_KEY_PRESS  = 5'd3;
	localparam logic [4:0] TY_CTRL       = 5'd4;
	localparam logic [4:0] TY_PROG       = 5'd5;
	localparam logic [4:0] TY_CHAN_PRESS = 5'd6;
	localparam logic [4:0] TY_PITCH      = 5'd7;
	localparam logic [4:0] TY_SONG_POS   = 5'd8;
	localparam logic [4:0] TY_SONG_SEL   = 5'd9;
	localparam logic [4:0] TY_CLOCK      = 5'd10;
	localparam logic [4:0] TY_START      = 5'd11;
	localparam logic [4:0] TY_CONT       = 5'd12;
	localparam logic [4:0] TY_STOP       = 5'd13;
	localparam logic [4:0] TY_TUNE       = 5'd14;
	localparam logic [4:0] TY_SENSE      = 5'd15;
	localparam logic [4:0] TY_SYS_RESET  = 5'd16;
	localparam logic [4:0] TY_SYSEX      = 5'd17;
	localparam logic [4:0] TY_QFRAME     = 5'd18;
	localparam logic [4:0] TY_PORT       = 5'd19;

	localparam logic [7:0] ST_EOX      = 8'hF7;
	localparam logic [7:0] ST_RT_FIRST = 8'hF8;
	localparam logic [7:0] PORT_MAX    = 8'd16;

	typedef enum logic [2:0] {
		PS_IDLE   = 3'd0,
		PS_FIRST  = 3'd1,
		PS_SECOND = 3'd2,
		PS_SINGLE = 3'd3,
		PS_QF     = 3'd4,
		PS_SYSEX  = 3'd5,
		PS_PORT   = 3'd6
	} parse_state_t;

	typedef struct packed {
		logic [2:0]  rkind;
		logic [4:0]  etype;
		logic [3:0]  chan;
		logic [7:0]  port;
		logic [6:0]  d1;
		logic [6:0]  d2;
		logic [31:0] etime;
		logic        last;
	} res_t;

	function automatic logic [4:0] status_type(input logic [7:0] c);
		logic [4:0] t;
		case (c[6:4])
			3'd0: t = TY_NOTE_OFF;
			3'd1: t = TY_NOTE_ON;
			3'd2: t = TY_KEY_PRESS;
			3'd3: t = TY_CTRL;
			3'd4: t = TY_PROG;
			3'd5: t = TY_CHAN_PRESS;
			3'd6: t = TY_PITCH;
			default: begin
				case (c[3:0])
					4'h0: t = TY_SYSEX;
					4'h1: t = TY_QFRAME;
					4'h2: t = TY_SONG_POS;
					4'h3: t = TY_SONG_SEL;
					4'h5: t = TY_PORT;
					4'h6: t = TY_TUNE;
					4'h8: t = TY_CLOCK;
					4'hA: t = TY_START;
					4'hB: t = TY_CONT;
					4'hC: t = TY_STOP;
					4'hE: t = TY_SENSE;
					4'hF: t = TY_SYS_RESET;
					default: t = TY_NONE;
				endcase
			end
		endcase
		return t;
	endfunction

	function automatic res_t mk_res(input logic [2:0] rkind, input logic [4:0] etype,
			input logic [3:0] chan, input logic [7:0] port, input logic [6:0] d1,
			input logic [6:0] d2, input logic [31:0] etime);
		res_t r;
		r.rkind = rkind;
		r.etype = etype;
		r.chan  = chan;
		r.port  = port;
		r.d1    = d1;
		r.d2    = d2;
		r.etime = etime;
		r.last  = 1'b0;
		return r;
	endfunction

endpackage

@@ rtl/core/midi_stream_parser_unit.sv @@
// midi_stream_parser_unit: MIDI byte parser with running status, sysex streaming.
// Depends on msp_pkg (codes, status table, result struct).
//
//  channel | dir | tdata                                  | tuser         | tlast
//  s_*     | in  | stream_byte[7:0] now_time[39:8]        | kind[1:0]     | -
//  m_*     | out | event_type, channel, port_number,      | result_kind   | last
//          |     | first_data, second_data, event_time    | [2:0]         |
//
// One item per cycle while s_tready is high: an input register, then the parse logic
// writes up to two results into an 8-entry result queue in the following cycle.
// s_tready depends only on queue fill and the input register, never on m_tready;
// a byte giving two results (sysex abort then status) puts both into the queue on one write.
// arst_n clears parse state, port and queue; no clearing pass.
`timescale 1ns / 1ps

module midi_stream_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // stream_byte[7:0], now_time[39:8]
	input  logic [1:0]  s_tuser,  // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,  // event_type[4:0], channel[8:5], port_number[16:9],
	                              // first_data[23:17], second_data[30:24],
	                              // event_time[62:31], zero[63]
	output logic [2:0]  m_tuser,  // result_kind[2:0]
	output logic        m_tlast
);
	import msp_pkg::*;

	logic        vld_s1;
	logic [1:0]  kind_s1;
	logic [7:0]  byte_s1;
	logic [31:0] time_s1;

	parse_state_t state_q, state_d, ps;
	logic [4:0]   mtype_q, mtype_d;
	logic [3:0]   mchan_q, mchan_d;
	logic [7:0]   port_q, port_d;
	logic [6:0]   d1_q, d1_d;
	logic [6:0]   d2_q, d2_d;
	logic [31:0]  htime_q, htime_d;

	res_t             fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wptr_q, rptr_q;
	logic [CNT_W-1:0] count_q;

	logic [4:0] st_t;
	logic       is_stat, in_sx, sx_abort, sx_end, run_status, is_data;
	logic       pre_v, st_v;
	res_t       pre_r, st_r, r0, r1;
	logic [1:0] push_n;
	logic       s_acc, pop;

	assign s_acc = s_tvalid && s_tready;
	assign pop   = m_tvalid && m_tready;
	assign s_tready = (count_q + (vld_s1 ? CNT_W'(MAX_RES) : CNT_W'(0)))
		<= CNT_W'(FIFO_DEPTH - MAX_RES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= s_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			kind_s1 <= s_tuser;
			byte_s1 <= s_tdata[7:0];
			time_s1 <= s_tdata[39:8];
		end
	end

	// decode
	always_comb begin
		case (state_q)
			PS_IDLE, PS_FIRST, PS_SECOND, PS_SINGLE, PS_QF, PS_SYSEX, PS_PORT: ps = state_q;
			default: ps = PS_IDLE;
		endcase
		st_t       = status_type(byte_s1);
		is_stat    = byte_s1[7];
		in_sx      = (ps == PS_SYSEX);
		sx_abort   = vld_s1 && in_sx &&
			(((kind_s1 == IK_ABANDON) || (kind_s1 == IK_RESET)) ||
			 ((kind_s1 == IK_BYTE) && is_stat && (byte_s1 < ST_RT_FIRST) && (st_t != TY_NONE)));
		sx_end     = vld_s1 && in_sx && (kind_s1 == IK_BYTE) && (byte_s1 == ST_EOX);
		run_status = vld_s1 && (kind_s1 == IK_BYTE) && is_stat;
		is_data    = vld_s1 && (kind_s1 == IK_BYTE) && !is_stat;
	end

	// next state
	always_comb begin
		state_d = ps;
		mtype_d = mtype_q;
		mchan_d = mchan_q;
		port_d  = port_q;
		d1_d    = d1_q;
		d2_d    = d2_q;
		htime_d = htime_q;
		if (vld_s1 && (kind_s1 == IK_ABANDON)) begin
			state_d = PS_IDLE;
		end else if (vld_s1 && (kind_s1 == IK_RESET)) begin
			state_d = PS_IDLE;
			mtype_d = '0;
			mchan_d = '0;
			port_d  = '0;
			d1_d    = '0;
			d2_d    = '0;
			htime_d = '0;
		end else if (run_status) begin
			if (sx_abort || sx_end) begin
				state_d = PS_IDLE;
			end
			if (st_t inside {[TY_NOTE_ON:TY_CTRL], TY_PITCH}) begin
				mtype_d = st_t;
				mchan_d = byte_s1[3:0];
				d1_d    = '0;
				d2_d    = '0;
				state_d = PS_FIRST;
			end else if (st_t inside {TY_PROG, TY_CHAN_PRESS}) begin
				mtype_d = st_t;
				mchan_d = byte_s1[3:0];
				d1_d    = '0;
				d2_d    = '0;
				state_d = PS_SINGLE;
			end else if (st_t inside {TY_SONG_POS, TY_SONG_SEL, TY_QFRAME}) begin
				mtype_d = st_t;
				mchan_d = '0;
				d1_d    = '0;
				d2_d    = '0;
				case (st_t)
					TY_SONG_POS: state_d = PS_FIRST;
					TY_SONG_SEL: state_d = PS_SINGLE;
					default:     state_d = PS_QF;
				endcase
			end else if (st_t == TY_SYSEX) begin
				htime_d = time_s1;
				state_d = PS_SYSEX;
			end else if (st_t == TY_PORT) begin
				state_d = PS_PORT;
			end
		end else if (is_data) begin
			case (ps)
				PS_FIRST: begin
					htime_d = time_s1;
					d1_d    = byte_s1[6:0];
					state_d = PS_SECOND;
				end
				PS_SECOND: begin
					d2_d    = byte_s1[6:0];
					state_d = PS_FIRST;
				end
				PS_SINGLE: begin
					htime_d = time_s1;
					d1_d    = byte_s1[6:0];
				end
				PS_QF: begin
					htime_d = time_s1;
					d1_d    = {4'd0, byte_s1[6:4]};
					d2_d    = {3'd0, byte_s1[3:0]};
				end
				PS_PORT: begin
					if (byte_s1 > PORT_MAX) port_d = '0;
					else port_d = byte_s1 - 8'd1;
				end
				default: ;
			endcase
		end
	end

	// results
	always_comb begin
		pre_v = 1'b0;
		pre_r = mk_res(RK_SX_ABORT, TY_SYSEX, 4'd0, port_q, 7'd0, 7'd0, htime_q);
		st_v  = 1'b0;
		st_r  = mk_res(RK_EVENT, st_t, 4'd0, port_q, 7'd0, 7'd0, time_s1);
		if (sx_abort) begin
			pre_v = 1'b1;
		end else if (sx_end) begin
			pre_v = 1'b1;
			pre_r.rkind = RK_SX_END;
		end else if (is_data) begin
			case (ps)
				PS_SECOND: begin
					pre_v = 1'b1;
					pre_r = mk_res(RK_EVENT, mtype_q, mchan_q, port_q, d1_q,
						byte_s1[6:0], htime_q);
				end
				PS_SINGLE: begin
					pre_v = 1'b1;
					pre_r = mk_res(RK_EVENT, mtype_q, mchan_q, port_q, byte_s1[6:0],
						d2_q, time_s1);
				end
				PS_QF: begin
					pre_v = 1'b1;
					pre_r = mk_res(RK_EVENT, mtype_q, mchan_q, port_q,
						{4'd0, byte_s1[6:4]}, {3'd0, byte_s1[3:0]}, time_s1);
				end
				PS_SYSEX: begin
					pre_v = 1'b1;
					pre_r = mk_res(RK_SX_DATA, TY_SYSEX, 4'd0, port_q, byte_s1[6:0],
						7'd0, htime_q);
				end
				default: ;
			endcase
		end
		if (run_status) begin
			if (st_t inside {[TY_CLOCK:TY_SYS_RESET]}) begin
				st_v = 1'b1;
			end else if (st_t == TY_SYSEX) begin
				st_v = 1'b1;
				st_r.rkind = RK_SX_START;
			end
		end
		r0 = pre_v ? pre_r : st_r;
		r1 = st_r;
		push_n = {1'b0, pre_v} + {1'b0, st_v};
		r0.last = (push_n == 2'd1);
		r1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PS_IDLE;
			mtype_q <= '0;
			mchan_q <= '0;
			port_q  <= '0;
			d1_q    <= '0;
			d2_q    <= '0;
			htime_q <= '0;
		end else if (vld_s1) begin
			state_q <= state_d;
			mtype_q <= mtype_d;
			mchan_q <= mchan_d;
			port_q  <= port_d;
			d1_q    <= d1_d;
			d2_q    <= d2_d;
			htime_q <= htime_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + PTR_W'(push_n);
			rptr_q  <= rptr_q + PTR_W'(pop);
			count_q <= count_q + CNT_W'(push_n) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) fifo_q[wptr_q] <= r0;
		if (push_n == 2'd2) fifo_q[wptr_q + PTR_W'(1)] <= r1;
	end

	res_t head;
	assign head     = fifo_q[rptr_q];
	assign m_tvalid = (count_q != '0);
	assign m_tdata  = {1'b0, head.etime, head.d2, head.d1, head.port, head.chan, head.etype};
	assign m_tuser  = head.rkind;
	assign m_tlast  = head.last;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(FIFO_DEPTH))
		else $error("result queue overfilled");

	a_two_abort: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n == 2'd2) |-> (r0.rkind == RK_SX_ABORT))
		else $error("two results without leading abort");

	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(push_n != 2'd0) |-> ((push_n == 2'd2) ? (r1.last && !r0.last) : r0.last))
		else $error("last marker misplaced");

	a_full_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && (kind_s1 == IK_RESET)) |=> ((state_q == PS_IDLE) && (port_q == 8'd0)))
		else $error("full reset did not clear state");

endmodule

@@ bench/midi_stream_parser_checker.sv @@
// midi_stream_parser_checker: watches both stream channels of the MIDI parser,
// predicts the event stream from the accepted bytes and compares every result.
// Depends on msp_pkg (item kinds, result kinds, type codes, result struct).
`timescale 1ns / 1ps

module midi_stream_parser_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [39:0] s_tdata,
	input  logic [1:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [63:0] m_tdata,
	input  logic [2:0]  m_tuser,
	input  logic        m_tlast,
	output int          fail_count,
	output int          pending,
	output int          bytes_seen,
	output int          ctrl_seen,
	output int          events_seen,
	output int          sysex_seen
);
	import msp_pkg::*;

	parse_state_t ps;
	logic [4:0]   msg_type;
	logic [3:0]   msg_chan;
	logic [7:0]   cur_port;
	logic [6:0]   held_d1;
	logic [6:0]   held_d2;
	logic [31:0]  held_time;

	res_t expected_events[$];
	res_t want;
	res_t got;
	int   produced;
	int   mismatches;
	int   n_bytes;
	int   n_ctrl;
	int   n_events;
	int   n_sysex;

	function automatic logic [4:0] type_of(input logic [7:0] b);
		logic [4:0] ty;
		ty = TY_NONE;
		case (b[7:4])
			4'h8: ty = TY_NOTE_OFF;
			4'h9: ty = TY_NOTE_ON;
			4'hA: ty = TY_KEY_PRESS;
			4'hB: ty = TY_CTRL;
			4'hC: ty = TY_PROG;
			4'hD: ty = TY_CHAN_PRESS;
			4'hE: ty = TY_PITCH;
			4'hF: begin
				case (b[3:0])
					4'h0: ty = TY_SYSEX;
					4'h1: ty = TY_QFRAME;
					4'h2: ty = TY_SONG_POS;
					4'h3: ty = TY_SONG_SEL;
					4'h5: ty = TY_PORT;
					4'h6: ty = TY_TUNE;
					4'h8: ty = TY_CLOCK;
					4'hA: ty = TY_START;
					4'hB: ty = TY_CONT;
					4'hC: ty = TY_STOP;
					4'hE: ty = TY_SENSE;
					4'hF: ty = TY_SYS_RESET;
					default: ty = TY_NONE;
				endcase
			end
			default: ty = TY_NONE;
		endcase
		return ty;
	endfunction

	task automatic clear_state();
		ps        = PS_IDLE;
		msg_type  = TY_NONE;
		msg_chan  = 4'd0;
		cur_port  = 8'd0;
		held_d1   = 7'd0;
		held_d2   = 7'd0;
		held_time = 32'd0;
	endtask

	task automatic put_result(input logic [2:0] rk, input logic [4:0] ty, input logic [3:0] ch,
			input logic [6:0] d1, input logic [6:0] d2, input logic [31:0] tm);
		res_t r;
		r.rkind = rk;
		r.etype = ty;
		r.chan  = ch;
		r.port  = cur_port;
		r.d1    = d1;
		r.d2    = d2;
		r.etime = tm;
		r.last  = 1'b0;
		expected_events.push_back(r);
		produced++;
	endtask

	task automatic open_message(input logic [4:0] ty, input logic [3:0] ch,
			input parse_state_t nxt);
		msg_type = ty;
		msg_chan = ch;
		held_d1  = 7'd0;
		held_d2  = 7'd0;
		ps       = nxt;
	endtask

	task automatic take_status(input logic [7:0] b, input logic [31:0] now);
		logic [4:0] ty;
		ty = type_of(b);
		case (ty)
			TY_NONE: ;
			TY_NOTE_ON, TY_NOTE_OFF, TY_KEY_PRESS, TY_CTRL, TY_PITCH:
				open_message(ty, b[3:0], PS_FIRST);
			TY_PROG, TY_CHAN_PRESS: open_message(ty, b[3:0], PS_SINGLE);
			TY_SONG_POS: open_message(ty, 4'd0, PS_FIRST);
			TY_SONG_SEL: open_message(ty, 4'd0, PS_SINGLE);
			TY_QFRAME:   open_message(ty, 4'd0, PS_QF);
			TY_PORT:     ps = PS_PORT;
			TY_SYSEX: begin
				held_time = now;
				ps = PS_SYSEX;
				put_result(RK_SX_START, TY_SYSEX, 4'd0, 7'd0, 7'd0, now);
			end
			// real-time and tune request: immediate event, running status untouched
			default: put_result(RK_EVENT, ty, 4'd0, 7'd0, 7'd0, now);
		endcase
	endtask

	task automatic parse_item(input logic [1:0] kind, input logic [7:0] b, input logic [31:0] now);
		res_t tail;
		produced = 0;
		if (kind == IK_ABANDON || kind == IK_RESET) begin
			if (ps == PS_SYSEX)
				put_result(RK_SX_ABORT, TY_SYSEX, 4'd0, 7'd0, 7'd0, held_time);
			if (kind == IK_RESET)
				clear_state();
			else
				ps = PS_IDLE;
		end else if (kind == IK_BYTE) begin
			if (b[7]) begin
				if (ps == PS_SYSEX && b < ST_RT_FIRST && type_of(b) != TY_NONE) begin
					put_result(RK_SX_ABORT, TY_SYSEX, 4'd0, 7'd0, 7'd0, held_time);
					ps = PS_IDLE;
					take_status(b, now);
				end else if (ps == PS_SYSEX && b == ST_EOX) begin
					ps = PS_IDLE;
					put_result(RK_SX_END, TY_SYSEX, 4'd0, 7'd0, 7'd0, held_time);
				end else begin
					take_status(b, now);
				end
			end else begin
				case (ps)
					PS_FIRST: begin
						held_time = now;
						held_d1 = b[6:0];
						ps = PS_SECOND;
					end
					PS_SECOND: begin
						held_d2 = b[6:0];
						ps = PS_FIRST;
						put_result(RK_EVENT, msg_type, msg_chan, held_d1, held_d2, held_time);
					end
					PS_SINGLE: begin
						held_time = now;
						held_d1 = b[6:0];
						put_result(RK_EVENT, msg_type, msg_chan, held_d1, held_d2, held_time);
					end
					PS_QF: begin
						held_time = now;
						held_d1 = {4'd0, b[6:4]};
						held_d2 = {3'd0, b[3:0]};
						put_result(RK_EVENT, msg_type, msg_chan, held_d1, held_d2, held_time);
					end
					PS_SYSEX: put_result(RK_SX_DATA, TY_SYSEX, 4'd0, b[6:0], 7'd0, held_time);
					// zero wraps to 255, above 16 falls back to port 0
					PS_PORT: cur_port = (b > PORT_MAX) ? 8'd0 : b - 8'd1;
					default: ;
				endcase
			end
		end
		if (produced > 0) begin
			tail = expected_events.pop_back();
			tail.last = 1'b1;
			expected_events.push_back(tail);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
			expected_events.delete();
			mismatches = 0;
			n_bytes = 0;
			n_ctrl = 0;
			n_events = 0;
			n_sysex = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got.rkind = m_tuser;
				got.etype = m_tdata[4:0];
				got.chan  = m_tdata[8:5];
				got.port  = m_tdata[16:9];
				got.d1    = m_tdata[23:17];
				got.d2    = m_tdata[30:24];
				got.etime = m_tdata[62:31];
				got.last  = m_tlast;
				if (got.rkind == RK_EVENT)
					n_events++;
				else
					n_sysex++;
				if (expected_events.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with nothing pending: kind=%0d type=%0d ch=%0d",
							$time, got.rkind, got.etype, got.chan);
				end else begin
					want = expected_events.pop_front();
					if (got !== want || m_tdata[63] !== 1'b0) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%0t: mismatch %0d", $time, mismatches);
							$display("  exp kind=%0d type=%0d ch=%0d port=%0d d1=%0d d2=%0d t=%h last=%0d",
								want.rkind, want.etype, want.chan, want.port, want.d1, want.d2,
								want.etime, want.last);
							$display("  got kind=%0d type=%0d ch=%0d port=%0d d1=%0d d2=%0d t=%h last=%0d pad=%0d",
								got.rkind, got.etype, got.chan, got.port, got.d1, got.d2,
								got.etime, got.last, m_tdata[63]);
						end
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == IK_BYTE)
					n_bytes++;
				else
					n_ctrl++;
				parse_item(s_tuser, s_tdata[7:0], s_tdata[39:8]);
			end
		end
		fail_count  <= mismatches;
		pending     <= expected_events.size();
		bytes_seen  <= n_bytes;
		ctrl_seen   <= n_ctrl;
		events_seen <= n_events;
		sysex_seen  <= n_sysex;
	end

endmodule

@@ bench/midi_stream_parser_unit_test.sv @@
// midi_stream_parser_unit_test: drives MIDI byte streams into the parser with random
// bursts, output stalls and long hold-offs; verdict from midi_stream_parser_checker.
// Depends on msp_pkg, midi_stream_parser_unit and midi_stream_parser_checker.
`timescale 1ns / 1ps

module midi_stream_parser_unit_test;
	import msp_pkg::*;

	localparam logic [1:0] IK_UNUSED      = 2'd3;
	localparam logic [7:0] SB_NOTE_OFF    = 8'h80;
	localparam logic [7:0] SB_NOTE_ON     = 8'h90;
	localparam logic [7:0] SB_CTRL        = 8'hB0;
	localparam logic [7:0] SB_SYSEX       = 8'hF0;
	localparam logic [7:0] SB_QFRAME      = 8'hF1;
	localparam logic [7:0] SB_SONG_POS    = 8'hF2;
	localparam logic [7:0] SB_SONG_SEL    = 8'hF3;
	localparam logic [7:0] SB_UNDEF_F4    = 8'hF4;
	localparam logic [7:0] SB_PORT        = 8'hF5;
	localparam logic [7:0] SB_TUNE        = 8'hF6;
	localparam logic [7:0] SB_CLOCK       = 8'hF8;
	localparam logic [7:0] SB_UNDEF_F9    = 8'hF9;
	localparam logic [7:0] SB_START       = 8'hFA;
	localparam logic [7:0] SB_CONT        = 8'hFB;
	localparam logic [7:0] SB_STOP        = 8'hFC;
	localparam logic [7:0] SB_UNDEF_FD    = 8'hFD;
	localparam logic [7:0] SB_SENSE       = 8'hFE;
	localparam logic [7:0] SB_SYS_RESET   = 8'hFF;
	localparam int         RANDOM_ITEMS   = 950;
	localparam int         HOLD_CYCLES    = 300;
	localparam int         WATCHDOG_LIMIT = 2000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [39:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	int fail_count;
	int pending;
	int bytes_seen;
	int ctrl_seen;
	int events_seen;
	int sysex_seen;

	logic [31:0] tick = 32'd0;
	int          burst_left = 0;
	bit          gap_mode = 1'b0;
	bit          hold_req = 1'b0;
	int          rx_mode = 0;
	int          rx_left = 0;
	int          sent = 0;
	int          idle_cycles = 0;
	int          next_phase;
	bit          held_once;
	bit          paused_once;

	always #1 clk = ~clk;

	midi_stream_parser_unit uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	midi_stream_parser_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.fail_count(fail_count), .pending(pending), .bytes_seen(bytes_seen),
		.ctrl_seen(ctrl_seen), .events_seen(events_seen), .sysex_seen(sysex_seen)
	);

	function automatic logic [31:0] next_time();
		if ($urandom_range(0, 19) == 0)
			tick = $urandom();
		else
			tick = tick + $urandom_range(0, 400);
		return tick;
	endfunction

	function automatic logic [7:0] rt_byte();
		logic [7:0] b;
		case ($urandom_range(0, 5))
			0: b = SB_CLOCK;
			1: b = SB_START;
			2: b = SB_CONT;
			3: b = SB_STOP;
			4: b = SB_SENSE;
			default: b = SB_SYS_RESET;
		endcase
		return b;
	endfunction

	task automatic send(input logic [1:0] k, input logic [7:0] b, input logic [31:0] t);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if (gap_mode) begin
				gap = $urandom_range(1, 6);
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {t, b};
		s_tuser  <= k;
		do @(posedge clk); while (!s_tready);
		sent++;
	endtask

	task automatic feed(input logic [7:0] b);
		send(IK_BYTE, b, next_time());
	endtask

	task automatic feed_data();
		if ($urandom_range(0, 11) == 0)
			feed(rt_byte());
		feed({1'b0, 7'($urandom)});
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic send_message();
		int pick;
		int n;
		logic [7:0] st;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			st = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
			if ($urandom_range(0, 3) != 0)
				feed(st);
			n = (st[6:4] == 3'd4 || st[6:4] == 3'd5) ? 1 : 2;
			repeat (n) feed_data();
		end else if (pick < 46) begin
			if ($urandom_range(0, 1)) begin
				feed(SB_SONG_POS);
				feed_data();
				feed_data();
			end else begin
				feed(SB_SONG_SEL);
				feed_data();
			end
		end else if (pick < 52) begin
			feed(SB_QFRAME);
			feed_data();
		end else if (pick < 58) begin
			feed(SB_PORT);
			repeat ($urandom_range(1, 3)) begin
				case ($urandom_range(0, 2))
					0: feed(8'h00);
					1: feed(8'($urandom_range(1, 16)));
					default: feed(8'($urandom_range(17, 127)));
				endcase
			end
		end else if (pick < 68) begin
			feed(rt_byte());
		end else if (pick < 70) begin
			feed(SB_TUNE);
		end else if (pick < 86) begin
			feed(SB_SYSEX);
			repeat ($urandom_range(0, 6)) feed_data();
			case ($urandom_range(0, 9))
				0: feed({1'b1, 3'($urandom_range(0, 6)), 4'($urandom)});
				1: feed(8'($urandom_range(SB_QFRAME, SB_TUNE)));
				2: send(IK_ABANDON, 8'($urandom), next_time());
				3: send(IK_RESET, 8'($urandom), next_time());
				4: begin
					feed(SB_UNDEF_FD);
					feed(ST_EOX);
				end
				default: feed(ST_EOX);
			endcase
		end else begin
			// noise: arbitrary bytes and control items
			case ($urandom_range(0, 4))
				0: send(IK_ABANDON, 8'($urandom), next_time());
				1: send(IK_RESET, 8'($urandom), next_time());
				2: send(IK_UNUSED, 8'($urandom), next_time());
				default: feed(8'($urandom));
			endcase
		end
	endtask

	// output side: own stall pattern, plus a long hold-off on request
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (rx_left == 0) begin
					rx_mode = $urandom_range(0, 2);
					rx_left = $urandom_range(30, 300);
				end
				rx_left--;
				case (rx_mode)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					default: m_tready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && !(s_tvalid && s_tready) && !(m_tvalid && m_tready))
			idle_cycles <= idle_cycles + 1;
		else
			idle_cycles <= 0;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles, %0d results pending",
				$time, WATCHDOG_LIMIT, pending);
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= IK_BYTE;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: corner bytes, running status, real-time inside messages, sysex exits
		feed(8'h45);
		send(IK_BYTE, SB_NOTE_ON | 8'h0F, 32'hFFFF_FFFF);
		send(IK_BYTE, 8'h7F, 32'hFFFF_FFFF);
		send(IK_BYTE, 8'h00, 32'h0000_0000);
		feed(SB_NOTE_OFF);
		feed(8'h01);
		feed(SB_CLOCK);
		feed(8'h02);
		feed(SB_QFRAME);
		feed(8'h7F);
		feed(SB_CTRL);
		feed(SB_TUNE);
		feed(8'h07);
		feed(8'h64);
		feed(SB_PORT);
		feed(8'h00);
		feed(8'h11);
		feed(SB_UNDEF_F4);
		feed(ST_EOX);
		feed(SB_SYSEX);
		feed(8'h7E);
		feed(SB_SENSE);
		feed(SB_UNDEF_F9);
		feed(ST_EOX);
		feed(SB_SYSEX);
		feed(SB_TUNE);
		feed(SB_SYSEX);
		send(IK_ABANDON, 8'h00, next_time());
		feed(SB_SYSEX);
		send(IK_RESET, 8'hFF, next_time());
		send(IK_UNUSED, 8'hFF, next_time());
		drain();

		sent = 0;
		held_once = 1'b0;
		paused_once = 1'b0;
		next_phase = $urandom_range(60, 200);
		while (sent < RANDOM_ITEMS) begin
			if (sent >= next_phase) begin
				gap_mode = ~gap_mode;
				next_phase = sent + $urandom_range(60, 200);
			end
			if (!held_once && sent >= RANDOM_ITEMS / 3) begin
				// stall the output long enough for the result queue to back up into the input
				held_once = 1'b1;
				gap_mode = 1'b0;
				burst_left = 100;
				hold_req = 1'b1;
				repeat (40) feed(rt_byte());
				burst_left = 0;
			end
			if (!paused_once && sent >= (2 * RANDOM_ITEMS) / 3) begin
				paused_once = 1'b1;
				drain();
			end
			send_message();
		end

		drain();
		repeat (16) @(posedge clk);
		$display("Summary: %0d bytes and %0d control items fed; %0d events, %0d sysex results checked",
			bytes_seen, ctrl_seen, events_seen, sysex_seen);
		$display("Covered running status, real-time interleave, port changes, sysex end/abort paths");
		if (fail_count == 0 && pending == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/msp_pkg.sv
rtl/core/midi_stream_parser_unit.sv
bench/midi_stream_parser_checker.sv
bench/midi_stream_parser_unit_test.sv
